>>> src/smx_pkg.sv
// shared constants, types and helper functions for the stereo mix accumulator
package smx_pkg;

   // mix store geometry
   localparam int BUF_FRAMES = 1024;
   localparam int ADDR_W     = $clog2(BUF_FRAMES);

   // field widths
   localparam int CMD_W      = 2;
   localparam int FRAME_W    = 10;
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int ACC_W      = 32;
   localparam int SCALED_W   = 18;
   localparam int GAIN_SHIFT = 15;

   // stream widths
   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_PAD_W  = RSP_DATA_W - FRAME_W - 2 * SAMPLE_W;

   // clamp limits
   localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);

   // command codes
   localparam logic [CMD_W-1:0] CMD_MIX   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   typedef logic [ADDR_W-1:0] addr_type;

   // control from the sequencer to both lanes
   typedef struct packed {
      addr_type rd_addr;
      logic     prod_load;
      logic     wr_en;
      addr_type wr_addr;
      logic     wr_zero;
      logic     rsp_load;
      logic     item_valid;
   } lane_ctrl_type;

   // frame index to store address
   function automatic addr_type to_addr(input logic [FRAME_W-1:0] frame);
      return addr_type'(frame);
   endfunction

   // frame lies inside the store
   function automatic logic frame_ok(input logic [FRAME_W-1:0] frame);
      return int'(frame) < BUF_FRAMES;
   endfunction

   // accumulator clamped to signed 16-bit
   function automatic logic signed [SAMPLE_W-1:0] clamp16(input logic signed [ACC_W-1:0] acc);
      logic signed [SAMPLE_W-1:0] res;
      if (acc < SAT_MIN) begin
         res = SAMPLE_W'(SAT_MIN);
      end else if (acc > SAT_MAX) begin
         res = SAMPLE_W'(SAT_MAX);
      end else begin
         res = SAMPLE_W'(acc);
      end
      return res;
   endfunction

endpackage

>>> src/stereo_mix_accumulator.sv
// stereo mix bus top level: stream ports, two channel lanes and the result register
// a read result is loaded from the execute state once any previous result has left rsp;
// rsp_tvalid is registered and rises after the load, and the result can then leave
// each command is accepted in idle, then executed with store write-back before the next;
// a read waits in its execute state while the previous result is still held on rsp
// reset and clear all: a sweep of 1024 frames zeroes the store, no requests taken meanwhile
module stereo_mix_accumulator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // frame, src_left, src_right, gain_left, gain_right, zero fill
   input  logic [smx_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd, mono
   input  logic [smx_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_frame, out_left, out_right, zero fill
   output logic [smx_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import smx_pkg::*;

   logic [CMD_W-1:0]           req_cmd;
   logic                       req_mono;
   logic [FRAME_W-1:0]         req_frame;
   logic signed [SAMPLE_W-1:0] req_left, req_right, right_sample;
   logic [GAIN_W-1:0]          req_gain_left, req_gain_right;
   lane_ctrl_type              ctrl;
   logic [FRAME_W-1:0]         item_frame;
   logic signed [SAMPLE_W-1:0] lane_left, lane_right;
   logic                       rsp_busy;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]         rsp_frame_ff;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_right_ff;

   // unpack request
   assign req_cmd        = req_tuser[CMD_W-1:0];
   assign req_mono       = req_tuser[CMD_W];
   assign req_frame      = req_tdata[FRAME_W-1:0];
   assign req_left       = req_tdata[FRAME_W +: SAMPLE_W];
   assign req_right      = req_tdata[FRAME_W+SAMPLE_W +: SAMPLE_W];
   assign req_gain_left  = req_tdata[FRAME_W+2*SAMPLE_W +: GAIN_W];
   assign req_gain_right = req_tdata[FRAME_W+2*SAMPLE_W+GAIN_W +: GAIN_W];

   // mono source feeds both sides
   assign right_sample = req_mono ? req_left : req_right;

   assign rsp_busy = rsp_valid_ff & ~rsp_tready;

   smx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_cmd),
      .req_frame  (req_frame),
      .rsp_busy   (rsp_busy),
      .ctrl       (ctrl),
      .item_frame (item_frame)
   );

   smx_lane u_lane_left (
      .clock   (clock),
      .ctrl    (ctrl),
      .sample  (req_left),
      .gain    (req_gain_left),
      .sat_out (lane_left)
   );

   smx_lane u_lane_right (
      .clock   (clock),
      .ctrl    (ctrl),
      .sample  (right_sample),
      .gain    (req_gain_right),
      .sat_out (lane_right)
   );

   // result register merges both lanes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tvalid && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_frame_ff <= item_frame;
         rsp_left_ff  <= ctrl.item_valid ? lane_left : '0;
         rsp_right_ff <= ctrl.item_valid ? lane_right : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_right_ff, rsp_left_ff, rsp_frame_ff};

   // checks
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> !rsp_busy)
      else $error("result register overwritten before transfer");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |=> rsp_tvalid)
      else $error("loaded result not offered");

   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> !(req_tvalid && req_tready))
      else $error("request transfer taken while a result is loaded");

endmodule

>>> src/smx_lane.sv
// one channel lane: gain scaling, accumulator store, accumulate and clamp
module smx_lane (
   input  logic                                 clock,
   input  smx_pkg::lane_ctrl_type               ctrl,
   input  logic signed [smx_pkg::SAMPLE_W-1:0]  sample,
   input  logic        [smx_pkg::GAIN_W-1:0]    gain,
   output logic signed [smx_pkg::SAMPLE_W-1:0]  sat_out
);
   import smx_pkg::*;

   logic [ACC_W-1:0]                   mem [BUF_FRAMES];
   logic signed [ACC_W-1:0]            rd_data_ff;
   logic signed [SCALED_W-1:0]         scaled_ff;
   logic signed [SCALED_W-1:0]         scaled_in;
   logic signed [SAMPLE_W+GAIN_W:0]    product;
   logic signed [ACC_W-1:0]            sum;
   logic [ACC_W-1:0]                   wr_data;

   // sample times unsigned q15 gain, floor shift by 15
   assign product   = sample * $signed({1'b0, gain});
   assign scaled_in = SCALED_W'(product >>> GAIN_SHIFT);

   always_ff @(posedge clock) begin
      if (ctrl.prod_load) begin
         scaled_ff <= scaled_in;
      end
   end

   // wrapping accumulate or clear
   assign sum     = rd_data_ff + ACC_W'(scaled_ff);
   assign wr_data = ctrl.wr_zero ? '0 : sum;

   // accumulator store, one write and one registered read
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[ctrl.rd_addr];
   end

   // clamped readout
   assign sat_out = clamp16(rd_data_ff);

endmodule

>>> src/smx_ctrl.sv
// command sequencer: accept, execute, and clearing sweep of the mix store
module smx_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [smx_pkg::CMD_W-1:0]     req_cmd,
   input  logic [smx_pkg::FRAME_W-1:0]   req_frame,
   input  logic                          rsp_busy,
   output smx_pkg::lane_ctrl_type        ctrl,
   output logic [smx_pkg::FRAME_W-1:0]   item_frame
);
   import smx_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_CLEAR = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   addr_type           count_ff, count_in;
   logic               accept;
   logic               item_valid;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign item_valid = frame_ok(frame_ff);
   assign item_frame = frame_ff;

   // next state and store control
   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      frame_in        = frame_ff;
      count_in        = count_ff;
      // read address follows the incoming frame while idle
      ctrl.rd_addr    = (state_ff == S_IDLE) ? to_addr(req_frame) : to_addr(frame_ff);
      ctrl.prod_load  = accept;
      ctrl.item_valid = item_valid;
      ctrl.wr_en      = 1'b0;
      ctrl.wr_addr    = to_addr(frame_ff);
      ctrl.wr_zero    = 1'b1;
      ctrl.rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               frame_in = req_frame;
               if (req_cmd == CMD_CLEAR) begin
                  state_in = S_CLEAR;
                  count_in = '0;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            priority if (cmd_ff == CMD_READ) begin
               if (!rsp_busy) begin
                  ctrl.rsp_load = 1'b1;
                  ctrl.wr_en    = item_valid;
                  state_in      = S_IDLE;
               end
            end else if (cmd_ff == CMD_MIX) begin
               ctrl.wr_en   = item_valid;
               ctrl.wr_zero = 1'b0;
               state_in     = S_IDLE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CLEAR: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = count_ff;
            count_in     = count_ff + 1'b1;
            if (count_ff == addr_type'(BUF_FRAMES - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            count_in = '0;
         end
      endcase
   end

   // control registers, reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // held item
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      frame_ff <= frame_in;
   end

   // checks
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ctrl.wr_en)
      else $error("store written while idle");

   a_accept_moves_on: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC || state_ff == S_CLEAR))
      else $error("accepted transfer not executed");

   a_sweep_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && count_ff != addr_type'(BUF_FRAMES - 1))
      |=> (state_ff == S_CLEAR && count_ff == $past(count_ff) + 1'b1))
      else $error("clearing sweep broken");

   a_exec_finishes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && !rsp_busy) |=> (state_ff == S_IDLE))
      else $error("execute step stalled without cause");

endmodule
